[hw/rtl/cgi_pkg.sv]
`default_nettype none

package cgi_pkg;

  // field widths
  localparam int unsigned COMP_W  = 16;  // one colour component
  localparam int unsigned IDXIN_W = 10;  // slot index of a query
  localparam int unsigned NC_W    = 11;  // num_colours register
  localparam int unsigned DEN_W   = 11;  // num_colours - 1
  localparam int unsigned NUM_W   = COMP_W + DEN_W;  // blend numerator
  localparam int unsigned NCOMP   = 3;   // red, green, blue
  localparam int unsigned STAT_W  = 2;

  localparam logic [NC_W-1:0] NC_RESET = 11'd256;

  // item kinds
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_CLAMP = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd3;

  // query sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIVP,
    ST_RD,
    ST_BLEND,
    ST_DINIT,
    ST_DIVB,
    ST_DONE
  } cgi_state_e;

endpackage

`default_nettype wire

[hw/rtl/colour_gradient_interpolator.sv]
`default_nettype none

// channel   | direction | handshake                    | payload
// ----------+-----------+------------------------------+-------------------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: red, green, blue, colour_index
//           |           |                              | tuser: mode, first_stop
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: out_red, out_green, out_blue
//           |           |                              | tuser: status
// cfg       | in        | cfg_valid_i/cfg_ready_o      | cfg_data_i: num_colours
//
// A load, and a query with no stops, go straight to the output register at the accepting edge.
// A query steps through the multiply and the bit-serial divide of the slot position, the stop
// read, the bit-serial blend multiply and the bit-serial blend divide, then waits for the output
// register; the three colour lanes run side by side.
// Reset clears the stop count, the sequencer and the output valid; the stop memory is not cleared.
// A stalled output holds its beat; a new beat is taken in the cycle the old one leaves.
module colour_gradient_interpolator
  import cgi_pkg::*;
#(
  parameter int unsigned MAX_STOPS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [63:0]          s_axis_tdata,   // red, green, blue, colour_index
  input  wire logic [1:0]           s_axis_tuser,   // mode, first_stop
  // result stream
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [47:0]          m_axis_tdata,   // out_red, out_green, out_blue
  output      logic [STAT_W-1:0]    m_axis_tuser,   // status
  // configuration
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [NC_W-1:0]      cfg_data_i
);

  // stop address width, stop count width, slot position width
  localparam int unsigned SW     = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int unsigned CW     = $clog2(MAX_STOPS + 1);
  localparam int unsigned POS_W  = IDXIN_W + SW;
  localparam int unsigned STEP_W = $clog2(POS_W + COMP_W);
  localparam int unsigned ROW_W  = NCOMP * COMP_W;

  cgi_state_e state_q, state_d;

  logic [CW-1:0]      count_q, count_d;
  logic [NC_W-1:0]    num_colours_q;
  logic               out_valid_q, out_valid_d;
  logic [ROW_W-1:0]   out_data_q, out_data_d;
  logic [STAT_W-1:0]  out_status_q, out_status_d;
  logic               out_load;

  logic [STAT_W-1:0]  status_q, status_d;
  logic [IDXIN_W-1:0] idx_q, idx_d;
  logic [DEN_W-1:0]   den_q, den_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [DEN_W-1:0]   prem_q, prem_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [DEN_W-1:0]   w0_q, w0_d;
  logic [DEN_W-1:0]   w1_q, w1_d;

  logic [NUM_W-1:0]   acc_q [NCOMP];
  logic [NUM_W-1:0]   acc_d [NCOMP];
  logic [DEN_W-1:0]   rem_q [NCOMP];
  logic [DEN_W-1:0]   rem_d [NCOMP];
  logic [COMP_W-1:0]  quo_q [NCOMP];
  logic [COMP_W-1:0]  quo_d [NCOMP];

  logic [ROW_W-1:0]   mem_q [MAX_STOPS];
  logic [ROW_W-1:0]   rd_lo_q;
  logic [ROW_W-1:0]   rd_hi_q;
  logic               mem_we;
  logic [SW-1:0]      wr_addr;
  logic [SW-1:0]      lo_addr;
  logic [SW-1:0]      hi_addr;

  logic               in_fire;
  logic               in_mode;
  logic               in_first;
  logic [IDXIN_W-1:0] in_idx;
  logic [DEN_W-1:0]   cur_den;
  logic [CW-1:0]      count_m1;
  logic [SW-1:0]      nm1;
  logic               table_full;

  // input fields and derived query values
  assign in_mode  = s_axis_tuser[0];
  assign in_first = s_axis_tuser[1];
  assign in_idx   = s_axis_tdata[ROW_W +: IDXIN_W];
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // input is taken only when idle and the output register is free or leaving
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);

  assign cur_den    = (num_colours_q < NC_W'(2)) ? DEN_W'(1) : DEN_W'(num_colours_q - NC_W'(1));
  assign count_m1   = count_q - CW'(1);
  assign nm1        = count_m1[SW-1:0];
  assign table_full = !in_first && (count_q == CW'(MAX_STOPS));
  assign wr_addr    = in_first ? '0 : count_q[SW-1:0];

  // neighbouring stops: quotient of the position divide and the next one up, held at the last stop
  assign lo_addr = pos_q[SW-1:0];
  assign hi_addr = (lo_addr == nm1) ? nm1 : SW'(lo_addr + SW'(1));

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

  // sequencer and datapath next values
  always_comb begin
    logic [DEN_W:0]  ptmp;
    logic            pge;
    logic [DEN_W:0]  dtmp;
    logic            dge;
    logic [NUM_W-1:0] addend0;
    logic [NUM_W-1:0] addend1;

    ptmp    = '0;
    pge     = 1'b0;
    dtmp    = '0;
    dge     = 1'b0;
    addend0 = '0;
    addend1 = '0;

    state_d      = state_q;
    count_d      = count_q;
    status_d     = status_q;
    idx_d        = idx_q;
    den_d        = den_q;
    pos_d        = pos_q;
    prem_d       = prem_q;
    step_d       = step_q;
    w0_d         = w0_q;
    w1_d         = w1_q;
    out_load     = 1'b0;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    for (int c = 0; c < NCOMP; c++) begin
      acc_d[c] = acc_q[c];
      rem_d[c] = rem_q[c];
      quo_d[c] = quo_q[c];
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_mode == MODE_LOAD) begin
            out_load   = 1'b1;
            out_data_d = '0;
            if (table_full) begin
              out_status_d = STATUS_FULL;
            end else begin
              out_status_d = STATUS_OK;
              mem_we       = 1'b1;
              count_d      = in_first ? CW'(1) : CW'(count_q + CW'(1));
            end
          end else if (count_q == '0) begin
            out_load     = 1'b1;
            out_data_d   = '0;
            out_status_d = STATUS_EMPTY;
          end else begin
            den_d = cur_den;
            if ({1'b0, in_idx} > cur_den) begin
              idx_d    = cur_den[IDXIN_W-1:0];
              status_d = STATUS_CLAMP;
            end else begin
              idx_d    = in_idx;
              status_d = STATUS_OK;
            end
            state_d = ST_MUL;
          end
        end
      end

      // slot position = index * (stops - 1)
      ST_MUL: begin
        pos_d   = {{SW{1'b0}}, idx_q} * {{IDXIN_W{1'b0}}, nm1};
        prem_d  = '0;
        step_d  = '0;
        state_d = ST_DIVP;
      end

      // restoring divide of the position by den, one bit a cycle
      ST_DIVP: begin
        ptmp   = {prem_q, pos_q[POS_W-1]};
        pge    = ptmp >= {1'b0, den_q};
        prem_d = pge ? DEN_W'(ptmp - {1'b0, den_q}) : ptmp[DEN_W-1:0];
        pos_d  = {pos_q[POS_W-2:0], pge};
        step_d = STEP_W'(step_q + STEP_W'(1));
        if (step_q == STEP_W'(POS_W - 1)) begin
          state_d = ST_RD;
        end
      end

      // stop rows are read this cycle, weights set up
      ST_RD: begin
        w1_d   = prem_q;
        w0_d   = DEN_W'(den_q - prem_q);
        step_d = '0;
        for (int c = 0; c < NCOMP; c++) begin
          acc_d[c] = '0;
        end
        state_d = ST_BLEND;
      end

      // lo*(den-rem) + hi*rem, weight bits msb first
      ST_BLEND: begin
        for (int c = 0; c < NCOMP; c++) begin
          addend0  = w0_q[DEN_W-1] ? NUM_W'(rd_lo_q[c*COMP_W +: COMP_W]) : '0;
          addend1  = w1_q[DEN_W-1] ? NUM_W'(rd_hi_q[c*COMP_W +: COMP_W]) : '0;
          acc_d[c] = NUM_W'({acc_q[c][NUM_W-2:0], 1'b0} + addend0 + addend1);
        end
        w0_d   = {w0_q[DEN_W-2:0], 1'b0};
        w1_d   = {w1_q[DEN_W-2:0], 1'b0};
        step_d = STEP_W'(step_q + STEP_W'(1));
        if (step_q == STEP_W'(DEN_W - 1)) begin
          state_d = ST_DINIT;
        end
      end

      // quotient fits 16 bits, so the upper numerator bits start below den
      ST_DINIT: begin
        for (int c = 0; c < NCOMP; c++) begin
          rem_d[c] = acc_q[c][NUM_W-1:COMP_W];
          quo_d[c] = acc_q[c][COMP_W-1:0];
        end
        step_d  = '0;
        state_d = ST_DIVB;
      end

      // restoring divide of each lane by den
      ST_DIVB: begin
        for (int c = 0; c < NCOMP; c++) begin
          dtmp     = {rem_q[c], quo_q[c][COMP_W-1]};
          dge      = dtmp >= {1'b0, den_q};
          rem_d[c] = dge ? DEN_W'(dtmp - {1'b0, den_q}) : dtmp[DEN_W-1:0];
          quo_d[c] = {quo_q[c][COMP_W-2:0], dge};
        end
        step_d = STEP_W'(step_q + STEP_W'(1));
        if (step_q == STEP_W'(COMP_W - 1)) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load     = 1'b1;
          out_data_d   = {quo_q[2], quo_q[1], quo_q[0]};
          out_status_d = status_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // output beat register
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      num_colours_q <= NC_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_colours_q <= cfg_data_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    idx_q        <= idx_d;
    den_q        <= den_d;
    pos_q        <= pos_d;
    prem_q       <= prem_d;
    step_q       <= step_d;
    w0_q         <= w0_d;
    w1_q         <= w1_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    for (int c = 0; c < NCOMP; c++) begin
      acc_q[c] <= acc_d[c];
      rem_q[c] <= rem_d[c];
      quo_q[c] <= quo_d[c];
    end
  end

  // stop memory, one write port and two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= s_axis_tdata[ROW_W-1:0];
    end
    if (state_q == ST_RD) begin
      rd_lo_q <= mem_q[lo_addr];
      rd_hi_q <= mem_q[hi_addr];
    end
  end

endmodule

`default_nettype wire
